[hdl/bdv_pkg.sv]
// Shared types and constants of the base64url decoder and validator.
package bdv_pkg;

	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

	localparam logic [5:0] ALPHA_HYPHEN     = 6'd62;
	localparam logic [5:0] ALPHA_UNDERSCORE = 6'd63;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
		logic [1:0] status;
	} result_t;

	// A character after classification: its 6-bit value, or a bad flag.
	typedef struct packed {
		logic [5:0] val;
		logic       bad;
		logic       last;
	} cls_t;

endpackage

[hdl/base64url_decoder_validator.sv]
// A result passes through the character queue and the result register before it shows on the result ports.
// Throughput: one character per cycle while the result register is free or being popped.
// A four-entry character queue lets push continue while results wait to be popped.
// Reset (arst_n low) empties the queue and the result register and clears the
// phase, held bits and error flag at once; no clearing pass is needed.
module base64url_decoder_validator import bdv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic wr_en;
	cls_t wr_data;
	logic q_full;
	logic q_rd;
	cls_t q_data;
	logic q_nonempty;

	bdv_front u_front (
		.push    (push),
		.full    (full),
		.item    (item),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.q_full  (q_full)
	);

	bdv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.full     (q_full),
		.rd_en    (q_rd),
		.rd_data  (q_data),
		.nonempty (q_nonempty)
	);

	bdv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

[hdl/bdv_front.sv]
// Front end: accepts characters and maps them through the URL-safe alphabet.
module bdv_front import bdv_pkg::*; (
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  wr_en,
	output cls_t  wr_data,
	input  logic  q_full
);

	logic [7:0] offs;

	always_comb begin
		wr_data.last = item.last_char;
		wr_data.bad  = 1'b0;
		offs         = 8'd0;
		wr_data.val  = 6'd0;
		if (item.ch inside {[8'h41:8'h5A]}) begin
			offs        = item.ch - 8'h41;
			wr_data.val = offs[5:0];
		end else if (item.ch inside {[8'h61:8'h7A]}) begin
			offs        = item.ch - 8'd71;
			wr_data.val = offs[5:0];
		end else if (item.ch inside {[8'h30:8'h39]}) begin
			offs        = item.ch + 8'd4;
			wr_data.val = offs[5:0];
		end else if (item.ch == 8'h2D) begin
			wr_data.val = ALPHA_HYPHEN;
		end else if (item.ch == 8'h5F) begin
			wr_data.val = ALPHA_UNDERSCORE;
		end else begin
			// Anything else, including every byte above 127, is invalid.
			wr_data.bad = 1'b1;
		end
	end

	assign full  = q_full;
	assign wr_en = push && !q_full;

endmodule

[hdl/bdv_queue.sv]
// Short queue of classified characters between the front and back ends.
module bdv_queue import bdv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cls_t wr_data,
	output logic full,
	input  logic rd_en,
	output cls_t rd_data,
	output logic nonempty
);

	cls_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/bdv_back.sv]
// Back end: splices 6-bit values into bytes and tracks length and errors.
module bdv_back import bdv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_nonempty,
	input  cls_t    q_data,
	output logic    q_rd,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic [1:0] phase_q;
	logic [5:0] held_q;
	logic       bad_q;
	logic       res_valid_q;
	result_t    res_q;

	logic       take;
	logic       bad_now;
	logic [7:0] byte_val;
	logic [5:0] held_nxt;
	logic       emit;
	result_t    res_nxt;

	// The result register is free when empty or being popped in this cycle.
	assign take    = q_nonempty && (!res_valid_q || pop);
	assign q_rd    = take;
	assign bad_now = bad_q || q_data.bad;

	always_comb begin
		case (phase_q)
			2'd0: begin
				byte_val = 8'd0;
				held_nxt = q_data.val;
			end
			2'd1: begin
				byte_val = {held_q, q_data.val[5:4]};
				held_nxt = {2'b00, q_data.val[3:0]};
			end
			2'd2: begin
				byte_val = {held_q[3:0], q_data.val[5:2]};
				held_nxt = {4'b0000, q_data.val[1:0]};
			end
			default: begin
				byte_val = {held_q[1:0], q_data.val};
				held_nxt = 6'd0;
			end
		endcase
	end

	always_comb begin
		res_nxt.out_byte = byte_val;
		res_nxt.last_out = q_data.last;
		res_nxt.status   = STATUS_OK;
		emit             = (phase_q != 2'd0) && !bad_now;
		if (q_data.last) begin
			emit = 1'b1;
			// A bad length outranks an invalid character.
			if (phase_q == 2'd0) begin
				res_nxt.status   = STATUS_BAD_LENGTH;
				res_nxt.out_byte = 8'd0;
			end else if (bad_now) begin
				res_nxt.status   = STATUS_BAD_CHAR;
				res_nxt.out_byte = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 2'd0;
			held_q      <= 6'd0;
			bad_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (q_data.last) begin
					phase_q <= 2'd0;
					held_q  <= 6'd0;
					bad_q   <= 1'b0;
				end else begin
					phase_q <= phase_q + 2'd1;
					held_q  <= held_nxt;
					bad_q   <= bad_now;
				end
				res_valid_q <= emit;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_nxt;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

[hdl/bdv_checker.sv]
// Port-level assertions for the decoder, bound to the top level.
module bdv_checker import bdv_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    full,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	// A waiting result stays until it is popped.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result changed while waiting");

	// Errors only close a string, and an error result carries a zero byte.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == STATUS_OK
			|| (result.last_out && result.out_byte == 8'd0
			&& (result.status == STATUS_BAD_CHAR || result.status == STATUS_BAD_LENGTH))))
		else $error("inconsistent result status");

	// Reset leaves both queues empty by the following edge.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queues not empty in reset");

	// Nothing can fill the queue in the cycle right after reset.
	a_no_early_full: assert property (@(posedge clk)
		!$past(arst_n) |-> !full)
		else $error("queue full right after reset");

endmodule

bind base64url_decoder_validator bdv_checker u_bdv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

[tb/sv/base64url_decoder_validator_tb.sv]
// Self-checking testbench for the unpadded base64url decoder and validator.
module base64url_decoder_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdv_pkg::*;

	localparam int N_RANDOM_CHARS = 2000;
	localparam int IDLE_LIMIT     = 2000;
	localparam int LONG_HOLD      = 120;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	base64url_decoder_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #4 clk = ~clk;

	string url_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	item_t   pending_chars[$];
	result_t expected_bytes[$];

	// Decoder state as the checker sees it.
	logic [1:0] dec_phase = '0;
	logic [5:0] dec_held = '0;
	logic       dec_bad = 1'b0;

	int errors = 0;
	int chars_taken = 0;
	int bytes_seen = 0;
	int strings_ok = 0;
	int strings_bad_char = 0;
	int strings_bad_len = 0;
	int idle_cycles = 0;
	bit long_hold_done = 1'b0;

	task automatic predict_decode(input item_t it);
		logic [5:0] v;
		logic       valid;
		logic [7:0] byte_val;
		logic       has_byte;
		result_t    r;
		logic [1:0] st;
		v = '0;
		valid = 1'b1;
		byte_val = '0;
		has_byte = 1'b1;
		if (it.ch >= "A" && it.ch <= "Z")
			v = 6'(it.ch - "A");
		else if (it.ch >= "a" && it.ch <= "z")
			v = 6'(it.ch - "a" + 26);
		else if (it.ch >= "0" && it.ch <= "9")
			v = 6'(it.ch - "0" + 52);
		else if (it.ch == "-")
			v = ALPHA_HYPHEN;
		else if (it.ch == "_")
			v = ALPHA_UNDERSCORE;
		else
			valid = 1'b0;
		if (!valid)
			dec_bad = 1'b1;
		case (dec_phase)
			2'd0: begin
				dec_held = v;
				has_byte = 1'b0;
			end
			2'd1: begin
				byte_val = {dec_held, v[5:4]};
				dec_held = {2'b00, v[3:0]};
			end
			2'd2: begin
				byte_val = {dec_held[3:0], v[5:2]};
				dec_held = {4'b0000, v[1:0]};
			end
			default: begin
				byte_val = {dec_held[1:0], v};
				dec_held = '0;
			end
		endcase
		if (it.last_char) begin
			// A string of length 1 mod 4 is reported as bad length even if it
			// also held an invalid character.
			if (dec_phase == 2'd0)
				st = STATUS_BAD_LENGTH;
			else if (dec_bad)
				st = STATUS_BAD_CHAR;
			else
				st = STATUS_OK;
			r.out_byte = (st == STATUS_OK) ? byte_val : 8'd0;
			r.last_out = 1'b1;
			r.status = st;
			expected_bytes.push_back(r);
			dec_phase = '0;
			dec_held = '0;
			dec_bad = 1'b0;
		end else begin
			dec_phase = dec_phase + 2'd1;
			if (has_byte && !dec_bad) begin
				r.out_byte = byte_val;
				r.last_out = 1'b0;
				r.status = STATUS_OK;
				expected_bytes.push_back(r);
			end
		end
	endtask

	task automatic queue_char(input logic [7:0] c, input logic close);
		item_t it;
		it.ch = c;
		it.last_char = close;
		pending_chars.push_back(it);
	endtask

	task automatic queue_text(input string s, input logic close);
		for (int k = 0; k < s.len(); k++)
			queue_char(s[k], close && (k == s.len() - 1));
	endtask

	// Accepted transactions on both sides, checking and the idle watchdog.
	always @(posedge clk) begin
		result_t exp_r;
		bit      moved;
		moved = 1'b0;
		if (arst_n && push && !full) begin
			predict_decode(item);
			void'(pending_chars.pop_front());
			chars_taken++;
			moved = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			moved = 1'b1;
			if (expected_bytes.size() == 0) begin
				$error("result with nothing expected: out_byte %0d last_out %0d status %0d",
					result.out_byte, result.last_out, result.status);
				errors++;
			end else begin
				exp_r = expected_bytes.pop_front();
				if (result.out_byte !== exp_r.out_byte) begin
					$error("out_byte mismatch: expected %0d, got %0d",
						exp_r.out_byte, result.out_byte);
					errors++;
				end
				if (result.last_out !== exp_r.last_out) begin
					$error("last_out mismatch: expected %0d, got %0d",
						exp_r.last_out, result.last_out);
					errors++;
				end
				if (result.status !== exp_r.status) begin
					$error("status mismatch: expected %0d, got %0d",
						exp_r.status, result.status);
					errors++;
				end
				if (exp_r.last_out) begin
					case (exp_r.status)
						STATUS_OK:       strings_ok++;
						STATUS_BAD_CHAR: strings_bad_char++;
						default:         strings_bad_len++;
					endcase
				end
				if (exp_r.status == STATUS_OK)
					bytes_seen++;
			end
		end
		if (moved || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 8;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (pending_chars.size() > 0) begin
			push <= 1'b1;
			item <= pending_chars[0];
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: pop rate follows a slow pattern, plus one long hold-off that
	// lets the block fill up while the sender keeps offering.
	int rx_cycle = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		int pop_pct;
		case (rx_cycle[8:7])
			2'd0:    pop_pct = 100;
			2'd1:    pop_pct = 75;
			2'd2:    pop_pct = 40;
			default: pop_pct = 90;
		endcase
		rx_cycle++;
		if (!long_hold_done && chars_taken >= 700) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(1, 100) <= pop_pct);
		end
	end

	initial begin
		int     n_queued;
		int     len;
		int     kind;
		int     bad_pos;
		logic [7:0] c;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings: alphabet edges, every closing phase, both errors.
		queue_text("AZ", 1'b1);
		queue_text("az0", 1'b1);
		queue_text("9-_A", 1'b1);
		queue_text("_", 1'b1);
		queue_text("Q/AB", 1'b1);
		queue_char(8'hFF, 1'b0);
		queue_char("A", 1'b1);
		queue_text("ABCD", 1'b0);
		queue_char(8'h80, 1'b1);
		queue_char(8'h00, 1'b0);
		queue_char(8'h7F, 1'b0);
		// Grave accent and open brace sit just outside the lowercase range.
		queue_char(8'h60, 1'b0);
		queue_char(8'h7B, 1'b1);

		// The sender holds off until the directed part has fully drained.
		wait (pending_chars.size() == 0 && expected_bytes.size() == 0);

		n_queued = 0;
		while (n_queued < N_RANDOM_CHARS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
				: $urandom_range(1, 12);
			kind = $urandom_range(0, 9);
			bad_pos = $urandom_range(0, len - 1);
			for (int k = 0; k < len; k++) begin
				c = url_alphabet[$urandom_range(0, 63)];
				if (kind == 0 || (kind == 1 && k == bad_pos))
					c = 8'($urandom_range(0, 255));
				queue_char(c, k == len - 1);
			end
			n_queued += len;
		end

		wait (pending_chars.size() == 0);
		wait (expected_bytes.size() == 0);
		repeat (8) @(posedge clk);

		$display("Decoded %0d characters into %0d bytes over %0d strings.",
			chars_taken, bytes_seen, strings_ok + strings_bad_char + strings_bad_len);
		$display("String endings: %0d ok, %0d invalid character, %0d bad length.",
			strings_ok, strings_bad_char, strings_bad_len);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
